FILE: src/tdrf_pkg.sv
package tdrf_pkg;

    localparam int COLUMNS    = 20;
    localparam int RING_DEPTH = 32;

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int RING_IW = $clog2(RING_DEPTH);
    localparam int RING_CW = $clog2(RING_DEPTH + 1);
    localparam int WORD_W  = 11;
    localparam int COL_IN_W = 6;

    localparam logic [7:0]        SPACE      = 8'h20;
    localparam logic [7:0]        DOT_BIT    = 8'h80;
    localparam logic [WORD_W-1:0] RESET_WORD = 11'h300;
    localparam logic [WORD_W-1:0] ROW0_BASE  = 11'h500;
    localparam logic [WORD_W-1:0] ROW1_BASE  = 11'h600;
    localparam logic [1:0]        LOADS_BOTH = 2'b11;
    localparam logic [1:0]        LOADS_ROW0 = 2'b01;
    localparam logic [1:0]        LOADS_ROW1 = 2'b10;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_BLANK   = 2'd1;
    localparam logic [1:0] MODE_INVERSE = 2'd2;

    localparam logic [2:0] CFG_PREFIX  = 3'd0;
    localparam logic [2:0] CFG_BUF_PTR = 3'd1;
    localparam logic [2:0] CFG_NORMAL  = 3'd2;
    localparam logic [2:0] CFG_BLANK   = 3'd3;
    localparam logic [2:0] CFG_INVERSE = 3'd4;

    typedef enum logic [3:0] {
        OP_TICK    = 4'd0,
        OP_WRITE   = 4'd1,
        OP_DOT     = 4'd2,
        OP_CLEAR   = 4'd3,
        OP_SCRL    = 4'd4,
        OP_SCRR    = 4'd5,
        OP_ROTL    = 4'd6,
        OP_ROTR    = 4'd7,
        OP_UP      = 4'd8,
        OP_DOWN    = 4'd9,
        OP_MODE    = 4'd10,
        OP_VISIBLE = 4'd11,
        OP_PUSHCMD = 4'd12,
        OP_REINIT  = 4'd13
    } t_op;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_DOT,
        CELL_CLEAR,
        CELL_SHL,
        CELL_SHR,
        CELL_UP,
        CELL_DOWN
    } t_cell_op;

    // one column: index 0 is row 0, index 1 is row 1
    typedef logic [1:0][7:0] t_pair;

    typedef struct packed {
        t_cell_op   op;
        logic       row;
        logic [7:0] pay;
    } t_cell_cmd;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } t_push;

    typedef logic [(2**COL_IN_W)-1:0][COL_W-1:0] t_col_lut;

    function automatic t_col_lut build_col_lut();
        t_col_lut lut;
        for (int i = 0; i < 2**COL_IN_W; i++) begin
            lut[i] = COL_W'(i % COLUMNS);
        end
        return lut;
    endfunction

    // input column folded into the row length
    localparam t_col_lut COL_LUT = build_col_lut();

endpackage

FILE: src/tdrf_cell.sv
module tdrf_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdrf_pkg::t_cell_cmd i_cmd,
    input  logic               i_sel,
    input  tdrf_pkg::t_pair    i_from_hi,
    input  tdrf_pkg::t_pair    i_from_lo,
    output tdrf_pkg::t_pair    o_chars
);

    tdrf_pkg::t_pair r_chars;
    tdrf_pkg::t_pair n_chars;

    always_comb begin
        n_chars = r_chars;
        case (i_cmd.op)
            tdrf_pkg::CELL_WRITE: begin
                if (i_sel) begin
                    n_chars[i_cmd.row] = i_cmd.pay;
                end
            end
            tdrf_pkg::CELL_DOT: begin
                if (i_sel) begin
                    n_chars[i_cmd.row] = r_chars[i_cmd.row] | tdrf_pkg::DOT_BIT;
                end
            end
            tdrf_pkg::CELL_CLEAR: n_chars[i_cmd.row] = tdrf_pkg::SPACE;
            tdrf_pkg::CELL_SHL:   n_chars[i_cmd.row] = i_from_hi[i_cmd.row];
            tdrf_pkg::CELL_SHR:   n_chars[i_cmd.row] = i_from_lo[i_cmd.row];
            tdrf_pkg::CELL_UP: begin
                n_chars[0] = r_chars[1];
                n_chars[1] = tdrf_pkg::SPACE;
            end
            tdrf_pkg::CELL_DOWN: begin
                n_chars[1] = r_chars[0];
                n_chars[0] = tdrf_pkg::SPACE;
            end
            default: n_chars = r_chars;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chars <= {tdrf_pkg::SPACE, tdrf_pkg::SPACE};
        end else begin
            r_chars <= n_chars;
        end
    end

    assign o_chars = r_chars;

endmodule

FILE: src/tdrf_ring.sv
module tdrf_ring (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tdrf_pkg::t_push               i_push,
    input  logic                          i_pop,
    input  logic                          i_restart,
    output logic [tdrf_pkg::WORD_W-1:0]   o_head,
    output logic                          o_pending
);

    localparam int IW    = tdrf_pkg::RING_IW;
    localparam int CW    = tdrf_pkg::RING_CW;
    localparam int SUM_W = IW + 1;
    localparam int DEPTH = tdrf_pkg::RING_DEPTH;

    logic [tdrf_pkg::WORD_W-1:0] r_ring [DEPTH];
    logic [IW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    logic [SUM_W-1:0] w_sum;
    logic [IW-1:0]    w_slot_a;
    logic [IW-1:0]    w_slot_b;
    logic             w_full;
    logic             w_write;

    assign w_sum    = SUM_W'(r_rd) + SUM_W'(r_cnt);
    assign w_slot_a = (w_sum >= SUM_W'(DEPTH)) ? IW'(w_sum - SUM_W'(DEPTH)) : IW'(w_sum);
    assign w_slot_b = (w_slot_a == IW'(DEPTH - 1)) ? '0 : w_slot_a + 1'b1;
    assign w_full   = (r_cnt >= CW'(DEPTH - 1));
    assign w_write  = i_push.valid && !w_full && !i_restart;

    always_comb begin
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_restart) begin
            n_rd  = '0;
            n_cnt = CW'(1);
        end else if (i_pop) begin
            n_rd  = (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            n_cnt = r_cnt - 1'b1;
        end else if (w_write) begin
            n_cnt = r_cnt + CW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_cnt <= CW'(1);
        end else begin
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // only entry zero has a reset value: others are read only after a push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_ring[0] <= tdrf_pkg::RESET_WORD;
        end else if (w_write) begin
            r_ring[w_slot_a] <= i_push.word_a;
            r_ring[w_slot_b] <= i_push.word_b;
        end
    end

    assign o_head    = r_ring[r_rd];
    assign o_pending = (r_cnt != '0);

endmodule

FILE: src/two_row_text_display_refresh_feeder.sv
// Feeds a two-row alphanumeric display bus from a 2 x 20 text store and a ring of pending
// command words. Every input beat is completed as it is accepted, edits, scrolls, rotations and
// row shifts included, since each column of text sits in its own cell that loads from its
// neighbours; the accept rate is one beat per cycle while the output register is free or being
// emptied. Only a tick (opcode 0) gives an output beat, in the cycle after its acceptance: a
// pending ring word first, otherwise the next character in row-interleaved scan order.
// Commands pushed to a ring with 31 or more words waiting are dropped. The text store comes
// up as spaces and the ring holds only the display reset word after reset.
module two_row_text_display_refresh_feeder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[3:0], row_sel[4], column[10:5], payload[18:11], load_select[20:19], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // reset_high[0], load_lines[2:1], data_byte[10:3], zero fill
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int N  = tdrf_pkg::COLUMNS;
    localparam int CW = tdrf_pkg::COL_W;
    localparam int WW = tdrf_pkg::WORD_W;

    logic [7:0] r_prefix;
    logic [7:0] r_buf_ptr;
    logic [7:0] r_normal;
    logic [7:0] r_blank;
    logic [7:0] r_inverse;

    logic [1:0][1:0] r_mode;
    logic [1:0][1:0] n_mode;
    logic [1:0]      r_vis;
    logic [1:0]      n_vis;
    logic            r_scan_row;
    logic            n_scan_row;
    logic [CW-1:0]   r_scan_col;
    logic [CW-1:0]   n_scan_col;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [WW-1:0]   r_out_word;
    logic [WW-1:0]   n_out_word;

    logic            w_accept;
    tdrf_pkg::t_op   w_op;
    logic            w_row;
    logic [CW-1:0]   w_col;
    logic [7:0]      w_pay;
    logic [1:0]      w_lds;

    tdrf_pkg::t_cell_cmd w_cell_cmd;
    tdrf_pkg::t_pair     w_cell_out [N];
    tdrf_pkg::t_pair     w_from_hi  [N];
    tdrf_pkg::t_pair     w_from_lo  [N];
    tdrf_pkg::t_pair     w_spaces;

    tdrf_pkg::t_push     w_push;
    logic                w_pop;
    logic                w_restart;
    logic [WW-1:0]       w_head;
    logic                w_pending;

    tdrf_pkg::t_pair     w_scan_pair;
    logic [7:0]          w_ch;
    logic [7:0]          w_sent;
    logic [1:0]          w_loads;
    logic [7:0]          w_cmd;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_op  = tdrf_pkg::t_op'(s_axis_tdata[3:0]);
    assign w_row = s_axis_tdata[4];
    assign w_col = tdrf_pkg::COL_LUT[s_axis_tdata[10:5]];
    assign w_pay = s_axis_tdata[18:11];
    assign w_lds = s_axis_tdata[20:19];

    assign w_spaces = {tdrf_pkg::SPACE, tdrf_pkg::SPACE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix  <= 8'h01;
            r_buf_ptr <= 8'hA0;
            r_normal  <= 8'h0E;
            r_blank   <= 8'h0F;
            r_inverse <= 8'h0D;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tdrf_pkg::CFG_PREFIX:  r_prefix  <= i_cfg_data;
                tdrf_pkg::CFG_BUF_PTR: r_buf_ptr <= i_cfg_data;
                tdrf_pkg::CFG_NORMAL:  r_normal  <= i_cfg_data;
                tdrf_pkg::CFG_BLANK:   r_blank   <= i_cfg_data;
                tdrf_pkg::CFG_INVERSE: r_inverse <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // text cells
    always_comb begin
        w_cell_cmd.row = w_row;
        w_cell_cmd.pay = w_pay;
        w_cell_cmd.op  = tdrf_pkg::CELL_HOLD;
        if (w_accept) begin
            case (w_op)
                tdrf_pkg::OP_WRITE: w_cell_cmd.op = tdrf_pkg::CELL_WRITE;
                tdrf_pkg::OP_DOT:   w_cell_cmd.op = tdrf_pkg::CELL_DOT;
                tdrf_pkg::OP_CLEAR: w_cell_cmd.op = tdrf_pkg::CELL_CLEAR;
                tdrf_pkg::OP_SCRL:  w_cell_cmd.op = tdrf_pkg::CELL_SHL;
                tdrf_pkg::OP_ROTL:  w_cell_cmd.op = tdrf_pkg::CELL_SHL;
                tdrf_pkg::OP_SCRR:  w_cell_cmd.op = tdrf_pkg::CELL_SHR;
                tdrf_pkg::OP_ROTR:  w_cell_cmd.op = tdrf_pkg::CELL_SHR;
                tdrf_pkg::OP_UP:    w_cell_cmd.op = tdrf_pkg::CELL_UP;
                tdrf_pkg::OP_DOWN:  w_cell_cmd.op = tdrf_pkg::CELL_DOWN;
                default:            w_cell_cmd.op = tdrf_pkg::CELL_HOLD;
            endcase
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        // the end cells take spaces, or the far end's chars on a rotate
        if (i == N - 1) begin : g_hi_end
            assign w_from_hi[i] = (w_op == tdrf_pkg::OP_ROTL) ? w_cell_out[0] : w_spaces;
        end else begin : g_hi
            assign w_from_hi[i] = w_cell_out[i+1];
        end
        if (i == 0) begin : g_lo_end
            assign w_from_lo[i] = (w_op == tdrf_pkg::OP_ROTR) ? w_cell_out[N-1] : w_spaces;
        end else begin : g_lo
            assign w_from_lo[i] = w_cell_out[i-1];
        end

        tdrf_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cell_cmd),
            .i_sel     (w_col == CW'(i)),
            .i_from_hi (w_from_hi[i]),
            .i_from_lo (w_from_lo[i]),
            .o_chars   (w_cell_out[i])
        );
    end

    tdrf_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_pop     (w_pop),
        .i_restart (w_restart),
        .o_head    (w_head),
        .o_pending (w_pending)
    );

    // character under the scan position with substitutions
    assign w_scan_pair = w_cell_out[r_scan_col];
    always_comb begin
        w_ch = w_scan_pair[r_scan_row];
        if (w_ch == r_prefix) begin
            w_ch = tdrf_pkg::SPACE;
        end
        if (r_mode[r_scan_row] == tdrf_pkg::MODE_BLANK && w_ch[7]) begin
            w_ch = tdrf_pkg::SPACE;
        end
        w_sent = r_vis[r_scan_row] ? w_ch : tdrf_pkg::SPACE;
    end

    always_comb begin
        n_mode      = r_mode;
        n_vis       = r_vis;
        n_scan_row  = r_scan_row;
        n_scan_col  = r_scan_col;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_word  = r_out_word;
        w_pop       = 1'b0;
        w_restart   = 1'b0;
        w_loads     = w_lds;
        w_cmd       = w_pay;
        w_push.valid = 1'b0;

        if (w_accept) begin
            case (w_op)
                tdrf_pkg::OP_TICK: begin
                    n_out_valid = 1'b1;
                    if (w_pending) begin
                        n_out_word = w_head;
                        w_pop      = 1'b1;
                    end else begin
                        n_out_word = (r_scan_row ? tdrf_pkg::ROW1_BASE : tdrf_pkg::ROW0_BASE)
                                     | {3'b000, w_sent};
                        if (!r_scan_row) begin
                            n_scan_row = 1'b1;
                        end else begin
                            n_scan_row = 1'b0;
                            if (r_scan_col == CW'(N - 1)) begin
                                n_scan_col   = '0;
                                w_loads      = tdrf_pkg::LOADS_BOTH;
                                w_cmd        = r_buf_ptr;
                                w_push.valid = 1'b1;
                            end else begin
                                n_scan_col = r_scan_col + 1'b1;
                            end
                        end
                    end
                end
                tdrf_pkg::OP_MODE: begin
                    w_loads = w_row ? tdrf_pkg::LOADS_ROW1 : tdrf_pkg::LOADS_ROW0;
                    if (w_pay[7:2] == 6'd0) begin
                        case (w_pay[1:0])
                            tdrf_pkg::MODE_NORMAL: begin
                                w_cmd        = r_normal;
                                w_push.valid = 1'b1;
                            end
                            tdrf_pkg::MODE_BLANK: begin
                                w_cmd        = r_blank;
                                w_push.valid = 1'b1;
                            end
                            tdrf_pkg::MODE_INVERSE: begin
                                w_cmd        = r_inverse;
                                w_push.valid = 1'b1;
                            end
                            default: w_push.valid = 1'b0;
                        endcase
                        if (w_push.valid) begin
                            n_mode[w_row] = w_pay[1:0];
                        end
                    end
                end
                tdrf_pkg::OP_VISIBLE: n_vis[w_row] = (w_pay != 8'd0);
                tdrf_pkg::OP_PUSHCMD: w_push.valid = 1'b1;
                tdrf_pkg::OP_REINIT: begin
                    w_restart  = 1'b1;
                    n_scan_row = 1'b0;
                    n_scan_col = '0;
                    n_mode     = {tdrf_pkg::MODE_NORMAL, tdrf_pkg::MODE_NORMAL};
                    n_vis      = 2'b11;
                end
                default: ;
            endcase
        end

        w_push.word_a = {1'b1, w_loads, r_prefix};
        w_push.word_b = {1'b1, w_loads, w_cmd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= {tdrf_pkg::MODE_NORMAL, tdrf_pkg::MODE_NORMAL};
            r_vis       <= 2'b11;
            r_scan_row  <= 1'b0;
            r_scan_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_vis       <= n_vis;
            r_scan_row  <= n_scan_row;
            r_scan_col  <= n_scan_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_word[7:0], r_out_word[9:8], r_out_word[10]};

endmodule
